@@ sv/fhm_pkg.sv @@
// Shared types, constants and codes of the FIFO hand-off mutex unit.
package fhm_pkg;

  // Sizes
  localparam int MAX_WAITERS    = 16;
  localparam int NUM_REQUESTERS = 64;
  localparam int CMDQ_DEPTH     = 2;

  localparam int OP_W   = 3;
  localparam int ID_W   = 6;
  localparam int DL_W   = 64;
  localparam int ST_W   = 3;
  localparam int IDX_W  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAITERS + 1);
  localparam int CQP_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQC_W  = $clog2(CMDQ_DEPTH + 1);

  // Stream widths, rounded up to whole bytes
  localparam int IN_BITS  = OP_W + ID_W + DL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ST_W + 1 + 1 + ID_W + ID_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_LOCK    = 3'd1,
    OP_TRYLOCK = 3'd2,
    OP_TLOCK   = 3'd3,
    OP_UNLOCK  = 3'd4,
    OP_TIMEOUT = 3'd5,
    OP_DESTROY = 3'd6
  } op_e;

  // Status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_STATE   = 3'd2,
    ST_WAITING = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EXEC
  } back_state_e;

  // Classified request handed from front to back
  typedef struct packed {
    op_e             op;
    logic            known_op;  // op code names an operation
    logic            args_ok;   // requester id valid, deadline non-zero for timed lock
    logic [ID_W-1:0] id;
  } cmd_t;

  // One result, status in the lowest bits
  typedef struct packed {
    logic [ID_W-1:0] owner_id;
    logic [ID_W-1:0] wake_id;
    logic            wake_valid;
    logic            acquired;
    status_e         status;
  } result_t;

endpackage

@@ sv/fhm_front.sv @@
// Front end: unpacks an incoming request and classifies op code and arguments.
module fhm_front (
  input  logic [fhm_pkg::IN_W-1:0] s_data_i,
  output fhm_pkg::cmd_t            cmd_o
);
  import fhm_pkg::*;

  logic [OP_W-1:0] op_raw;
  logic [ID_W-1:0] id;
  logic [DL_W-1:0] deadline;
  logic            id_ok;
  logic            known;

  assign op_raw   = s_data_i[OP_W-1:0];
  assign id       = s_data_i[OP_W +: ID_W];
  assign deadline = s_data_i[OP_W+ID_W +: DL_W];

  // id zero means no task; ids beyond the requester range are rejected too
  assign id_ok = (id != '0) && (32'(id) < NUM_REQUESTERS);

  // recognise the op code
  always_comb begin
    case (op_e'(op_raw))
      OP_INIT, OP_LOCK, OP_TRYLOCK, OP_TLOCK,
      OP_UNLOCK, OP_TIMEOUT, OP_DESTROY: known = 1'b1;
      default:                           known = 1'b0;
    endcase
  end

  // build the classified request
  always_comb begin
    cmd_o.op       = op_e'(op_raw);
    cmd_o.known_op = known;
    cmd_o.args_ok  = id_ok && !((op_e'(op_raw) == OP_TLOCK) && (deadline == '0));
    cmd_o.id       = id;
  end

endmodule

@@ sv/fhm_cmd_queue.sv @@
// Short request queue between front and back ends.
module fhm_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fhm_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fhm_pkg::cmd_t pop_data_o
);
  import fhm_pkg::*;

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [CQP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQC_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CQC_W'(CMDQ_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CQP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CQP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/fhm_back.sv @@
// Back end: mutex state, waiter queue search and compaction, result register.
module fhm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  fhm_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             timed_ok_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output fhm_pkg::result_t res_o
);
  import fhm_pkg::*;

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic             ready_q, ready_d;
  logic             held_q, held_d;
  logic [ID_W-1:0]  owner_q, owner_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  waitq_q [MAX_WAITERS];
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             out_vld_q;
  result_t          out_q;
  result_t          res;
  logic             out_free, exec_fire, scan_hit, scan_end;
  logic             push_en, drop_en;
  logic [IDX_W-1:0] drop_pos;

  assign out_free = !out_vld_q || res_ready_i;
  assign scan_end = (scan_q >= count_q);
  assign scan_hit = !scan_end && (waitq_q[scan_q[IDX_W-1:0]] == cmd_q.id);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = BK_SCAN;
      BK_SCAN: if (scan_end || scan_hit) state_d = BK_EXEC;
      BK_EXEC: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // sequencer outputs and scan bookkeeping
  always_comb begin
    cmd_pop_o = 1'b0;
    exec_fire = 1'b0;
    scan_d    = scan_q;
    found_d   = found_q;
    pos_d     = pos_q;
    case (state_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        scan_d    = '0;
        found_d   = 1'b0;
      end
      BK_SCAN: begin
        if (scan_hit) begin
          found_d = 1'b1;
          pos_d   = scan_q[IDX_W-1:0];
        end else if (!scan_end) begin
          scan_d = scan_q + 1'b1;
        end
      end
      BK_EXEC: exec_fire = out_free;
      default: ;
    endcase
  end

  // carry out the request
  always_comb begin
    ready_d        = ready_q;
    held_d         = held_q;
    owner_d        = owner_q;
    count_d        = count_q;
    push_en        = 1'b0;
    drop_en        = 1'b0;
    drop_pos       = pos_q;
    res.status     = ST_INVALID;
    res.acquired   = 1'b0;
    res.wake_valid = 1'b0;
    res.wake_id    = '0;
    if (cmd_q.known_op && cmd_q.op == OP_INIT) begin
      ready_d    = 1'b1;
      held_d     = 1'b0;
      owner_d    = '0;
      count_d    = '0;
      res.status = ST_OK;
    end else if (!ready_q || !cmd_q.known_op) begin
      res.status = ST_INVALID;
    end else if (cmd_q.op == OP_DESTROY) begin
      if (held_q || count_q != '0) begin
        res.status = ST_STATE;
      end else begin
        ready_d    = 1'b0;
        res.status = ST_OK;
      end
    end else if (!cmd_q.args_ok) begin
      res.status = ST_INVALID;
    end else begin
      case (cmd_q.op)
        OP_LOCK, OP_TLOCK: begin
          if (!held_q) begin
            held_d     = 1'b1;
            owner_d    = cmd_q.id;
            res.status = ST_OK;
          end else if (owner_q == cmd_q.id) begin
            res.status = ST_STATE;
          end else if (cmd_q.op == OP_TLOCK && !timed_ok_i) begin
            res.status = ST_INVALID;
          end else if (found_q) begin
            res.status = ST_STATE;
          end else if (count_q >= CNT_W'(MAX_WAITERS)) begin
            res.status = ST_FULL;
          end else begin
            push_en    = 1'b1;
            count_d    = count_q + 1'b1;
            res.status = ST_WAITING;
          end
        end
        OP_TRYLOCK: begin
          if (!held_q) begin
            held_d       = 1'b1;
            owner_d      = cmd_q.id;
            res.acquired = 1'b1;
          end
          res.status = ST_OK;
        end
        OP_UNLOCK: begin
          if (!held_q || owner_q != cmd_q.id) begin
            res.status = ST_STATE;
          end else if (count_q != '0) begin
            // hand the lock straight to the queue head
            owner_d        = waitq_q[0];
            drop_en        = 1'b1;
            drop_pos       = '0;
            count_d        = count_q - 1'b1;
            res.wake_valid = 1'b1;
            res.wake_id    = waitq_q[0];
            res.status     = ST_OK;
          end else begin
            held_d     = 1'b0;
            owner_d    = '0;
            res.status = ST_OK;
          end
        end
        OP_TIMEOUT: begin
          if (held_q && owner_q == cmd_q.id) begin
            res.status = ST_OK;
          end else begin
            if (found_q) begin
              drop_en = 1'b1;
              count_d = count_q - 1'b1;
            end
            res.status = ST_TIMEOUT;
          end
        end
        default: res.status = ST_INVALID;
      endcase
    end
    res.owner_id = (ready_d && held_d) ? owner_d : '0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      ready_q   <= 1'b0;
      held_q    <= 1'b0;
      owner_q   <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      found_q   <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      found_q <= found_d;
      pos_q   <= pos_d;
      if (exec_fire) begin
        ready_q   <= ready_d;
        held_q    <= held_d;
        owner_q   <= owner_d;
        count_q   <= count_d;
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload: latched request, result, waiter entries
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (exec_fire) begin
      out_q <= res;
    end
    // removal closes the gap by moving every later entry up one place
    if (exec_fire && drop_en) begin
      for (int i = 0; i < MAX_WAITERS - 1; i++) begin
        if (IDX_W'(i) >= drop_pos) begin
          waitq_q[i] <= waitq_q[i+1];
        end
      end
    end
    if (exec_fire && push_en) begin
      waitq_q[count_q[IDX_W-1:0]] <= cmd_q.id;
    end
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_WAITERS))
    else $error("waiter count beyond queue depth");

  a_idle_when_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> (!held_q && count_q == '0))
    else $error("uninitialised mutex holds state");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC && found_q) |-> (CNT_W'(pos_q) < count_q))
    else $error("found waiter lies past queue fill");

  a_wake_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && res.wake_valid) |=> (out_q.status == ST_OK && out_q.owner_id != '0))
    else $error("wake without successful hand-off");

endmodule

@@ sv/fifo_handoff_mutex_unit.sv @@
// Hardware mutex with FIFO waiter queue and direct hand-off: top level.
// Each request yields exactly one result. A request is classified on entry
// and held in a two-entry queue, so up to two more requests are taken while
// one is being served or its result waits. The waiter queue is searched one
// entry per cycle, up to 16 entries, until the caller is found or the queue
// end is reached. Removal from the queue moves every later entry up one place
// at once. The user must write timed_wait_supported through the cfg channel
// only while idle; the block itself does not enforce this.
module fifo_handoff_mutex_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // tdata: op[2:0], requester_id[8:3], deadline[72:9], zeros above
  input  logic [fhm_pkg::IN_W-1:0]  s_axis_tdata_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: status[2:0], acquired[3], wake_valid[4], wake_id[10:5],
  //        owner_id[16:11], zeros above
  output logic [fhm_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_data_i
);
  import fhm_pkg::*;

  cmd_t    front_cmd, queue_cmd;
  logic    queue_full, queue_valid, queue_pop;
  logic    timed_ok_q;
  result_t res;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timed_ok_q <= 1'b1;
    end else if (cfg_valid_i) begin
      timed_ok_q <= cfg_data_i;
    end
  end

  fhm_front u_front (
    .s_data_i (s_axis_tdata_i),
    .cmd_o    (front_cmd)
  );

  assign s_axis_tready_o = !queue_full;

  fhm_cmd_queue u_cmd_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_cmd)
  );

  fhm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .timed_ok_i  (timed_ok_q),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {{(OUT_W - OUT_BITS){1'b0}}, res};

endmodule
